>>> rtl/sliding_window_request_limiter_defines.svh
// assertion macros for the sliding window request limiter checker
`ifndef SLIDING_WINDOW_REQUEST_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_REQUEST_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SWRL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define SWRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swrl_pkg.sv
// shared widths, register codes and controller/datapath interface types
`default_nettype none

package swrl_pkg;

    localparam int RING_DEPTH = 16;

    localparam int STAMP_W    = 48;
    localparam int LIMIT_W    = 4;
    localparam int WINDOW_W   = 16;
    localparam int GUARD_W    = 10;
    localparam int WAIT_W     = 17;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * RING_DEPTH);
    localparam int LIM_CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MS      = 2'd2;

    localparam logic [LIMIT_W-1:0]  RESET_LIMIT  = 4'd10;
    localparam logic [WINDOW_W-1:0] RESET_WINDOW = 16'd1000;
    localparam logic [GUARD_W-1:0]  RESET_GUARD  = 10'd10;

    typedef struct packed {
        logic load_now;
        logic expire;
        logic keep_diff;
        logic compute;
        logic record;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic expired;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/swrl_datapath.sv
// stamp ring, config registers, expiry compare, wait arithmetic and output register
`default_nettype none

module swrl_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [swrl_pkg::STAMP_W-1:0]    s_now_ms,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic                           m_must_wait,
    output logic [swrl_pkg::WAIT_W-1:0]     m_wait_ms,
    output logic [swrl_pkg::HELD_W-1:0]     m_held_count,
    input  swrl_pkg::ctrl_cmd_t            cmd,
    output swrl_pkg::dp_stat_t             stat
);
    import swrl_pkg::*;

    logic [STAMP_W-1:0]  ring_mem [RING_DEPTH];
    logic [STAMP_W-1:0]  rdata_reg;

    logic [LIMIT_W-1:0]  limit_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic [GUARD_W-1:0]  guard_reg;

    logic [STAMP_W-1:0]  now_reg;
    logic [STAMP_W:0]    diff_reg;
    logic [IDX_W-1:0]    oldest_reg, oldest_next, oldest_inc;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                must_reg;
    logic [WAIT_W-1:0]   wait_reg;

    logic                m_valid_reg;
    logic                m_must_reg;
    logic [WAIT_W-1:0]   m_wait_reg;
    logic [HELD_W-1:0]   m_held_reg;

    logic [STAMP_W:0]    diff;
    logic [STAMP_W:0]    win_ext;
    logic [WAIT_W-1:0]   cap;
    logic [WAIT_W-1:0]   wait_pos;
    logic                full;
    logic                hit;
    logic [SUM_W-1:0]    wr_sum;
    logic [IDX_W-1:0]    wr_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= RESET_LIMIT;
            window_reg <= RESET_WINDOW;
            guard_reg  <= RESET_GUARD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_REQUEST_LIMIT: limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_WINDOW_MS:     window_reg <= cfg_wdata[WINDOW_W-1:0];
                CFG_GUARD_MS:      guard_reg  <= cfg_wdata[GUARD_W-1:0];
                default: ;
            endcase
        end
    end

    // signed age of the oldest held stamp, a later stamp gives a negative age
    assign diff    = {1'b0, now_reg} - {1'b0, rdata_reg};
    assign win_ext = (STAMP_W + 1)'(window_reg);
    assign cap     = WAIT_W'(window_reg) + WAIT_W'(guard_reg);
    assign wait_pos = cap - diff_reg[WAIT_W-1:0];

    assign full = (count_reg == CNT_W'(RING_DEPTH));
    assign hit  = (count_reg != '0) && (LIM_CMP_W'(count_reg) >= LIM_CMP_W'(limit_reg));

    assign oldest_inc = (oldest_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign wr_sum     = SUM_W'(oldest_reg) + SUM_W'(count_reg);

    always_comb begin
        if (full) begin
            wr_addr = oldest_reg;
        end else if (wr_sum >= SUM_W'(RING_DEPTH)) begin
            wr_addr = IDX_W'(wr_sum - SUM_W'(RING_DEPTH));
        end else begin
            wr_addr = IDX_W'(wr_sum);
        end
    end

    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        if (cmd.expire) begin
            oldest_next = oldest_inc;
            count_next  = count_reg - 1'b1;
        end else if (cmd.record) begin
            if (full) begin
                oldest_next = oldest_inc;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end else begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
        end
    end

    // read runs every cycle at the next oldest slot so the data is registered for the next cycle
    always_ff @(posedge aclk) begin
        rdata_reg <= ring_mem[oldest_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.record) begin
            ring_mem[wr_addr] <= now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_now) begin
            now_reg <= s_now_ms;
        end
        if (cmd.keep_diff) begin
            diff_reg <= diff;
        end
        if (cmd.compute) begin
            if (!hit) begin
                must_reg <= 1'b0;
                wait_reg <= '0;
            end else if (diff_reg[STAMP_W]) begin
                must_reg <= 1'b1;
                wait_reg <= cap;
            end else begin
                must_reg <= (wait_pos != '0);
                wait_reg <= wait_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_must_reg <= must_reg;
            m_wait_reg <= wait_reg;
            m_held_reg <= HELD_W'(count_reg);
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.expired    = $signed(diff) > $signed(win_ext);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_must_wait  = m_must_reg;
    assign m_wait_ms    = m_wait_reg;
    assign m_held_count = m_held_reg;

endmodule

`default_nettype wire

>>> rtl/swrl_ctrl.sv
// controller state machine sequencing expiry, check, record and output
`default_nettype none

module swrl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swrl_pkg::dp_stat_t  stat,
    output swrl_pkg::ctrl_cmd_t cmd
);
    import swrl_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPIRE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_RECORD = 3'd3;
    localparam logic [2:0] ST_OUTPUT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_now = 1'b1;
                    state_next   = ST_EXPIRE;
                end
            end
            ST_EXPIRE: begin
                // one stamp a cycle, stop at the first one still inside the window or when none are left
                if (stat.count_zero) begin
                    state_next = ST_CHECK;
                end else if (stat.expired) begin
                    cmd.expire = 1'b1;
                end else begin
                    cmd.keep_diff = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.compute = 1'b1;
                state_next  = ST_RECORD;
            end
            ST_RECORD: begin
                cmd.record = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/sliding_window_request_limiter.sv
// Sliding window request limiter: each accepted beat carries the request time in
// milliseconds; the block drops held stamps older than window_ms, reports a wait
// when one or more and at least request_limit stamps remain, records the new
// stamp in a 16-entry ring (overwriting the oldest when full) and returns one
// result beat. After a beat is accepted the controller expires stamps one per
// cycle (0 to 16 of them, as the ring memory has one read port), then checks
// the wait, writes the ring and loads the output register; only then can the
// next beat be taken. A result waiting in the output register holds the
// controller in its last step until it is taken. Config writes go through
// cfg_wr_en/cfg_index/cfg_wdata (0 request_limit, 1 window_ms, 2 guard_ms) and
// must only be issued while the block is idle.
`default_nettype none

module sliding_window_request_limiter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [swrl_pkg::STAMP_W-1:0]    s_now_ms,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_must_wait,
    output logic [swrl_pkg::WAIT_W-1:0]     m_wait_ms,
    output logic [swrl_pkg::HELD_W-1:0]     m_held_count
);
    import swrl_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    swrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    swrl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_now_ms     (s_now_ms),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_must_wait  (m_must_wait),
        .m_wait_ms    (m_wait_ms),
        .m_held_count (m_held_count),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

>>> rtl/swrl_checker.sv
// port-level checker for the request limiter and its bind
`default_nettype none

`include "sliding_window_request_limiter_defines.svh"

module swrl_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_must_wait,
    input  logic [swrl_pkg::WAIT_W-1:0]     m_wait_ms,
    input  logic [swrl_pkg::HELD_W-1:0]     m_held_count
);

    // stalled result beat holds
    `SWRL_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_must_wait) && $stable(m_wait_ms) && $stable(m_held_count), "result beat changed while stalled")

    // no wait value without the wait flag
    `SWRL_ASSERT_SAME(a_no_wait_zero, m_valid && !m_must_wait, m_wait_ms == '0, "wait_ms nonzero without must_wait")

    // wait never exceeds window plus guard at their largest
    `SWRL_ASSERT_SAME(a_wait_range, m_valid, m_wait_ms <= 17'd66558, "wait_ms out of range")

    // one item at a time: busy right after an accept
    `SWRL_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after an accepted beat")

endmodule

bind sliding_window_request_limiter swrl_checker u_checker (.*);

`default_nettype wire

>>> dv/tb_sliding_window_request_limiter.sv
// testbench for the sliding window request limiter: directed and random request streams
`timescale 1ns / 1ps

module tb_sliding_window_request_limiter;
    import swrl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              must_wait;
        logic [WAIT_W-1:0] wait_ms;
        logic [HELD_W-1:0] held_count;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_REQUEST_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [STAMP_W-1:0]    s_now_ms = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_must_wait;
    logic [WAIT_W-1:0]     m_wait_ms;
    logic [HELD_W-1:0]     m_held_count;

    // limiter state as seen by the testbench
    logic [STAMP_W-1:0]  stamp_log [RING_DEPTH];
    logic [IDX_W-1:0]    oldest_pos = '0;
    int                  held_n = 0;
    logic [LIMIT_W-1:0]  limit_cfg = RESET_LIMIT;
    logic [WINDOW_W-1:0] window_cfg = RESET_WINDOW;
    logic [GUARD_W-1:0]  guard_cfg = RESET_GUARD;

    verdict_t pending_verdicts [$];
    int       beats_sent = 0;
    int       beats_checked = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       ready_hold = 0;
    bit       sender_eager = 1'b0;
    bit       receiver_eager = 1'b0;

    sliding_window_request_limiter i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_must_wait  (m_must_wait),
        .m_wait_ms    (m_wait_ms),
        .m_held_count (m_held_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(input bit eager);
        return eager ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    // expire old stamps, check the limit, record the new stamp
    function automatic verdict_t admit_request(input logic [STAMP_W-1:0] now_ms);
        verdict_t         v;
        longint           oldest_stamp;
        longint           wait_calc;
        longint           wait_cap;
        logic [IDX_W-1:0] slot;
        v = '0;
        while (held_n > 0) begin
            oldest_stamp = longint'(stamp_log[oldest_pos]);
            if (longint'(now_ms) - oldest_stamp > longint'(window_cfg)) begin
                oldest_pos = oldest_pos + 1'b1;
                held_n--;
            end else begin
                break;
            end
        end
        if (held_n > 0 && held_n >= int'(limit_cfg)) begin
            oldest_stamp = longint'(stamp_log[oldest_pos]);
            wait_calc = oldest_stamp + longint'(window_cfg) - longint'(now_ms)
                        + longint'(guard_cfg);
            wait_cap = longint'(window_cfg) + longint'(guard_cfg);
            if (wait_calc > 0) begin
                if (wait_calc > wait_cap)
                    wait_calc = wait_cap;
                v.must_wait = 1'b1;
                v.wait_ms = wait_calc[WAIT_W-1:0];
            end
        end
        // full ring: overwrite the oldest stamp
        if (held_n >= RING_DEPTH) begin
            oldest_pos = oldest_pos + 1'b1;
            held_n--;
        end
        slot = oldest_pos + IDX_W'(held_n);
        stamp_log[slot] = now_ms;
        held_n++;
        v.held_count = HELD_W'(held_n);
        return v;
    endfunction

    task automatic send_request(input logic [STAMP_W-1:0] now_val);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            sender_eager = ($urandom_range(0, 2) == 0);
        gap = draw_wait(sender_eager);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_now_ms <= now_val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_verdicts.insert(pending_verdicts.size(), admit_request(now_val));
        beats_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (beats_checked != beats_sent);
    endtask

    task automatic program_limits(input logic [LIMIT_W-1:0] lim,
                                  input logic [WINDOW_W-1:0] win,
                                  input logic [GUARD_W-1:0] grd);
        wait_for_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_REQUEST_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        cfg_index <= CFG_WINDOW_MS;
        cfg_wdata <= CFG_DATA_W'(win);
        @(posedge aclk);
        cfg_index <= CFG_GUARD_MS;
        cfg_wdata <= CFG_DATA_W'(grd);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_cfg = lim;
        window_cfg = win;
        guard_cfg = grd;
    endtask

    // result side: random stalls while a beat is waiting
    always @(posedge aclk) begin
        verdict_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    log_mismatch($sformatf("unexpected beat: must_wait=%0b wait_ms=%0d held=%0d",
                                           m_must_wait, m_wait_ms, m_held_count));
                end else begin
                    due = pending_verdicts[0];
                    pending_verdicts.delete(0);
                    if (due.must_wait !== m_must_wait || due.wait_ms !== m_wait_ms ||
                        due.held_count !== m_held_count)
                        log_mismatch($sformatf(
                            "beat %0d: expected must_wait=%0b wait_ms=%0d held=%0d, got %0b %0d %0d",
                            beats_checked, due.must_wait, due.wait_ms, due.held_count,
                            m_must_wait, m_wait_ms, m_held_count));
                end
                beats_checked <= beats_checked + 1;
                if ($urandom_range(0, 39) == 0)
                    receiver_eager = ($urandom_range(0, 2) == 0);
                ready_hold = draw_wait(receiver_eager);
            end else if (m_valid && ready_hold > 0) begin
                ready_hold--;
            end
            m_ready <= (ready_hold == 0);
        end
    end

    task automatic test_extreme_stamps();
        send_request('0);
        send_request({STAMP_W{1'b1}});
    endtask

    // same stamp over and over fills the ring, then one from the past saturates the wait
    task automatic test_full_ring();
        logic [STAMP_W-1:0] t;
        program_limits(4'd1, 16'hFFFF, 10'h3FF);
        t = 48'h8000_0000_0000;
        repeat (RING_DEPTH) send_request(t);
        send_request(t - 1'b1);
    endtask

    // stamp exactly one window old is kept and gives a wait of zero
    task automatic test_zero_wait();
        logic [STAMP_W-1:0] t;
        program_limits(4'd1, 16'd100, 10'd0);
        t = 48'h8000_0003_0000;
        send_request(t);
        send_request(t + 48'd100);
    endtask

    task automatic test_limit_and_window_zero();
        logic [STAMP_W-1:0] t;
        program_limits(4'd0, 16'd0, 10'd5);
        t = 48'h8000_0003_0000 + 48'd250;
        send_request(t);
        send_request(t);
        send_request(t + 1'b1);
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [STAMP_W-1:0]  t;
        logic [LIMIT_W-1:0]  lim;
        logic [WINDOW_W-1:0] win;
        int unsigned         step_span;
        int unsigned         pick;
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: begin
                    program_limits(4'd1, 16'd1, 10'd0);
                end
                1: begin
                    program_limits(4'd15, 16'hFFFF, 10'h3FF);
                end
                2: begin
                    program_limits(RESET_LIMIT, RESET_WINDOW, RESET_GUARD);
                end
                3: begin
                    program_limits(4'd0, 16'd50, 10'd0);
                end
                default: begin
                    pick = $urandom_range(0, 5);
                    lim = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 15));
                    pick = $urandom_range(0, 4);
                    if (pick == 0)
                        win = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
                    else if (pick == 4)
                        win = 16'($urandom_range(0, 65535));
                    else
                        win = 16'($urandom_range(1, 3000));
                    program_limits(lim, win, 10'($urandom_range(0, 1023)));
                end
            endcase
            step_span = 2 * int'(window_cfg) / ((limit_cfg == 0) ? 1 : int'(limit_cfg)) + 2;
            t = 48'({$urandom(), $urandom()});
            for (int n = 0; n < per_phase; n++) begin
                // hold off the sender once per odd phase until the block has drained
                if (p % 2 == 1 && n == per_phase / 2)
                    wait_for_drain();
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    t = t + 48'($urandom_range(0, step_span));
                else if (pick < 92)
                    t = t - 48'($urandom_range(1, 2 * int'(window_cfg) + 2));
                else if (pick < 96)
                    t = t + 48'($urandom());
                else
                    t = 48'({$urandom(), $urandom()});
                send_request(t);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_stamps();
        test_full_ring();
        test_zero_wait();
        test_limit_and_window_zero();
        test_random_traffic(10, 128);
        wait_for_drain();
        repeat (40) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            log_mismatch($sformatf("%0d expected beats never arrived", pending_verdicts.size()));
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
